// ===== design/bsds_pkg.sv =====
// Shared types and constants of the byte stream delimiter splitter.
// Used by the channel interfaces, the scan logic, the result queue and the top level.
`timescale 1ns / 1ps

package bsds_pkg;

   localparam int MAX_DELIM_LEN = 8;
   localparam int BYTE_W        = 8;
   localparam int DELIM_W       = MAX_DELIM_LEN * BYTE_W;
   localparam int DLEN_REG_W    = 4;
   // Active delimiter length and window fill (after the new byte), 1 to MAX_DELIM_LEN.
   localparam int LEN_W         = $clog2(MAX_DELIM_LEN + 1);
   // Held byte count between beats, 0 to MAX_DELIM_LEN - 1.
   localparam int WIN_CNT_W     = $clog2(MAX_DELIM_LEN);
   localparam int MAX_RESULTS   = MAX_DELIM_LEN + 1;
   localparam int RES_CNT_W     = $clog2(MAX_RESULTS + 1);
   localparam int CSR_IDX_W     = 1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DELIM_BYTES  = 1'b0,
      CSR_DELIM_LENGTH = 1'b1
   } csr_index_type;

   typedef logic [MAX_DELIM_LEN-1:0][BYTE_W-1:0] window_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              is_boundary;
   } res_type;

   typedef res_type [MAX_RESULTS-1:0] res_list_type;

   typedef struct packed {
      res_list_type         results;
      logic [RES_CNT_W-1:0] count;
   } res_batch_type;

   typedef struct packed {
      res_batch_type        batch;
      window_type           window;
      logic [WIN_CNT_W-1:0] window_count;
      logic                 segment_open;
   } scan_type;

endpackage

// ===== design/bsds_req_if.sv =====
// Input channel of the delimiter splitter: one buffer byte per beat.
// Depends on bsds_pkg for the byte width.
`timescale 1ns / 1ps

interface bsds_req_if
   import bsds_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;
   logic              end_of_buffer;

   modport source (output valid, output data_byte, output end_of_buffer, input ready);
   modport sink (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

// ===== design/bsds_rsp_if.sv =====
// Result channel of the delimiter splitter: one segment byte or boundary per beat.
// Depends on bsds_pkg for the byte width.
`timescale 1ns / 1ps

interface bsds_rsp_if
   import bsds_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] out_byte;
   logic              is_boundary;
   logic              last_of_run;

   modport source (output valid, output out_byte, output is_boundary, output last_of_run,
                   input ready);
   modport sink (input valid, input out_byte, input is_boundary, input last_of_run,
                 output ready);
endinterface

// ===== design/bsds_scan.sv =====
// Combinational scan of the held window plus one new byte against the delimiter.
// Produces the result list of the beat and the next window state; uses bsds_pkg.
`timescale 1ns / 1ps

module bsds_scan
   import bsds_pkg::*;
   (
   input  window_type           win,
   input  logic [WIN_CNT_W-1:0] win_count,
   input  logic                 segment_open,
   input  logic [BYTE_W-1:0]    data_byte,
   input  logic                 end_of_buffer,
   input  window_type           pattern,
   input  logic [LEN_W-1:0]     len,
   output scan_type             scan
   );

   window_type               w;
   logic [LEN_W-1:0]         n;
   logic [MAX_DELIM_LEN-1:0] full_hit;
   logic [MAX_DELIM_LEN-1:0] tail_hit;
   logic [LEN_W-1:0]         skip;
   logic                     stopped;
   logic [WIN_CNT_W-1:0]     keep;
   logic                     open;
   logic [RES_CNT_W-1:0]     k;
   res_list_type             res;

   // Window with the new byte appended after the held bytes.
   always_comb begin
      w = win;
      for (int i = 0; i < MAX_DELIM_LEN; i++) begin
         if (WIN_CNT_W'(i) == win_count) begin
            w[i] = data_byte;
         end
      end
      n = LEN_W'(win_count) + LEN_W'(1);
   end

   // For every start position: a complete match, or a partial match that runs
   // to the end of the window and may still grow into one.
   always_comb begin
      for (int s = 0; s < MAX_DELIM_LEN; s++) begin
         full_hit[s] = ({1'b0, LEN_W'(s)} + {1'b0, len}) <= {1'b0, n};
         tail_hit[s] = !full_hit[s] && (LEN_W'(s) < n);
         for (int i = 0; i < MAX_DELIM_LEN - s; i++) begin
            if ((LEN_W'(s + i) < n) && (LEN_W'(i) < len) && (w[s + i] != pattern[i])) begin
               full_hit[s] = 1'b0;
               tail_hit[s] = 1'b0;
            end
         end
      end
   end

   // Leftmost, non-overlapping walk over the window.
   always_comb begin
      skip    = '0;
      stopped = 1'b0;
      keep    = '0;
      open    = segment_open;
      k       = '0;
      res     = '0;
      for (int s = 0; s < MAX_DELIM_LEN; s++) begin
         if (LEN_W'(s) < n) begin
            if (skip != '0) begin
               skip = skip - LEN_W'(1);
            end else if (stopped) begin
               if (end_of_buffer) begin
                  res[k] = '{out_byte: w[s], is_boundary: 1'b0};
                  k      = k + RES_CNT_W'(1);
                  open   = 1'b1;
               end
            end else if (full_hit[s]) begin
               if (open) begin
                  res[k] = '{out_byte: '0, is_boundary: 1'b1};
                  k      = k + RES_CNT_W'(1);
                  open   = 1'b0;
               end
               skip = len - LEN_W'(1);
            end else if (tail_hit[s]) begin
               stopped = 1'b1;
               keep    = WIN_CNT_W'(s);
               if (end_of_buffer) begin
                  res[k] = '{out_byte: w[s], is_boundary: 1'b0};
                  k      = k + RES_CNT_W'(1);
                  open   = 1'b1;
               end
            end else begin
               res[k] = '{out_byte: w[s], is_boundary: 1'b0};
               k      = k + RES_CNT_W'(1);
               open   = 1'b1;
            end
         end
      end
      if (end_of_buffer && open) begin
         res[k] = '{out_byte: '0, is_boundary: 1'b1};
         k      = k + RES_CNT_W'(1);
         open   = 1'b0;
      end

      scan.batch.results = res;
      scan.batch.count   = k;
      scan.segment_open  = open;
      // The held tail moves to the front; keep counts bytes, so scale it to bits.
      scan.window        = w >> {keep, 3'b000};
      if (stopped && !end_of_buffer) begin
         scan.window_count = WIN_CNT_W'(n - LEN_W'(keep));
      end else begin
         scan.window_count = '0;
      end
   end

endmodule

// ===== design/bsds_resp_queue.sv =====
// Result register bank: holds the results of one input beat and hands them out
// one per beat on the result channel. Uses bsds_pkg and bsds_rsp_if.
`timescale 1ns / 1ps

module bsds_resp_queue
   import bsds_pkg::*;
   (
   input  logic          clock,
   input  logic          reset,
   input  logic          load,
   input  res_batch_type batch,
   output logic          free,
   bsds_rsp_if.source    rsp
   );

   res_list_type         res_ff, res_in;
   logic [RES_CNT_W-1:0] count_ff, count_in;
   logic [RES_CNT_W-1:0] head_ff, head_in;
   logic                 take;
   res_type              cur;

   assign cur             = res_ff[head_ff];
   assign rsp.valid       = head_ff != count_ff;
   assign rsp.out_byte    = cur.out_byte;
   assign rsp.is_boundary = cur.is_boundary;
   assign rsp.last_of_run = (head_ff + RES_CNT_W'(1)) == count_ff;

   assign take = rsp.valid && rsp.ready;
   // Free when empty or when the final result goes out in this cycle.
   assign free = (head_ff == count_ff) || (take && rsp.last_of_run);

   always_comb begin
      res_in   = res_ff;
      count_in = count_ff;
      head_in  = head_ff;
      if (load) begin
         res_in   = batch.results;
         count_in = batch.count;
         head_in  = '0;
      end else if (take) begin
         head_in = head_ff + RES_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
      if (reset) begin
         count_ff <= '0;
         head_ff  <= '0;
      end else begin
         count_ff <= count_in;
         head_ff  <= head_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      load |-> free)
      else $error("result batch loaded over undelivered results");
   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      load |=> rsp.valid)
      else $error("loaded batch shows no result");
   a_last_empties: assert property (@(posedge clock) disable iff (reset)
      take && rsp.last_of_run && !load |=> !rsp.valid)
      else $error("result shown after the last of a run");
   a_head_bound: assert property (@(posedge clock) disable iff (reset)
      head_ff <= count_ff)
      else $error("read pointer beyond the batch");
`endif

endmodule

// ===== design/byte_stream_delimiter_splitter.sv =====
// A result passes the input register, which feeds the scan, and then the result register
// bank, which loads the scan's results once it is free. Throughput: one byte per cycle
// while each byte gives at most one result and the result port is ready; a byte with more
// results stalls the input until all are out (up to nine on a flush at end of buffer).
// Reset (synchronous): empties all stages, clears the window and the open segment,
// and sets the delimiter to zero with length one; there is no clearing pass.
`timescale 1ns / 1ps

module byte_stream_delimiter_splitter
   import bsds_pkg::*;
   (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DELIM_W-1:0]   csr_wdata,
   bsds_req_if.sink             req_bus,
   bsds_rsp_if.source           rsp_bus
   );

   logic [DELIM_W-1:0]    delim_bytes_ff, delim_bytes_in;
   logic [DLEN_REG_W-1:0] delim_len_ff, delim_len_in;
   logic                  s1_valid_ff, s1_valid_in;
   logic [BYTE_W-1:0]     s1_byte_ff, s1_byte_in;
   logic                  s1_eob_ff, s1_eob_in;
   window_type            win_ff, win_in;
   logic [WIN_CNT_W-1:0]  win_count_ff, win_count_in;
   logic                  seg_open_ff, seg_open_in;
   logic [LEN_W-1:0]      len;
   scan_type              scan;
   logic                  q_free;
   logic                  s1_move;
   logic                  q_load;
   logic                  accept;

   // Length zero acts as one; lengths above the maximum saturate.
   always_comb begin
      if (delim_len_ff == '0) begin
         len = LEN_W'(1);
      end else if (DLEN_REG_W'(MAX_DELIM_LEN) < delim_len_ff) begin
         len = LEN_W'(MAX_DELIM_LEN);
      end else begin
         len = LEN_W'(delim_len_ff);
      end
   end

   always_comb begin
      delim_bytes_in = delim_bytes_ff;
      delim_len_in   = delim_len_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_DELIM_BYTES: begin
               delim_bytes_in = csr_wdata;
            end
            CSR_DELIM_LENGTH: begin
               delim_len_in = csr_wdata[DLEN_REG_W-1:0];
            end
            default: begin
               delim_bytes_in = delim_bytes_ff;
            end
         endcase
      end
   end

   bsds_scan u_scan (
      .win           (win_ff),
      .win_count     (win_count_ff),
      .segment_open  (seg_open_ff),
      .data_byte     (s1_byte_ff),
      .end_of_buffer (s1_eob_ff),
      .pattern       (window_type'(delim_bytes_ff)),
      .len           (len),
      .scan          (scan)
   );

   // A beat with no results updates the state without touching the result bank.
   assign s1_move         = s1_valid_ff && ((scan.batch.count == '0) || q_free);
   assign q_load          = s1_move && (scan.batch.count != '0);
   assign req_bus.ready   = !s1_valid_ff || s1_move;
   assign accept          = req_bus.valid && req_bus.ready;

   bsds_resp_queue u_resp_queue (
      .clock (clock),
      .reset (reset),
      .load  (q_load),
      .batch (scan.batch),
      .free  (q_free),
      .rsp   (rsp_bus)
   );

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_byte_in   = s1_byte_ff;
      s1_eob_in    = s1_eob_ff;
      win_in       = win_ff;
      win_count_in = win_count_ff;
      seg_open_in  = seg_open_ff;
      if (s1_move) begin
         s1_valid_in  = 1'b0;
         win_in       = scan.window;
         win_count_in = scan.window_count;
         seg_open_in  = scan.segment_open;
      end
      if (accept) begin
         s1_valid_in = 1'b1;
         s1_byte_in  = req_bus.data_byte;
         s1_eob_in   = req_bus.end_of_buffer;
      end
   end

   always_ff @(posedge clock) begin
      s1_byte_ff <= s1_byte_in;
      s1_eob_ff  <= s1_eob_in;
      win_ff     <= win_in;
      if (reset) begin
         delim_bytes_ff <= '0;
         delim_len_ff   <= DLEN_REG_W'(1);
         s1_valid_ff    <= 1'b0;
         win_count_ff   <= '0;
         seg_open_ff    <= 1'b0;
      end else begin
         delim_bytes_ff <= delim_bytes_in;
         delim_len_ff   <= delim_len_in;
         s1_valid_ff    <= s1_valid_in;
         win_count_ff   <= win_count_in;
         seg_open_ff    <= seg_open_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_eob_flushes: assert property (@(posedge clock) disable iff (reset)
      s1_move && s1_eob_ff |=> (win_count_ff == '0) && !seg_open_ff)
      else $error("window or segment left open after end of buffer");
   a_accept_holds: assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_valid_ff)
      else $error("accepted beat not held in the input register");
   a_stall_keeps: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_move |=> s1_valid_ff && $stable(s1_byte_ff) && $stable(s1_eob_ff))
      else $error("stalled beat lost or changed");
`endif

endmodule
